/* hdl/spn_block_cipher_128_defines.svh */
// Assertion macros shared by the cipher RTL
`ifndef SPN_BLOCK_CIPHER_128_DEFINES_SVH
`define SPN_BLOCK_CIPHER_128_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SPN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define SPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/spn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package spn_pkg;

  localparam int RoundCountDef = 5;
  localparam int RoundMax      = 5;
  localparam logic [7:0] MixXor = 8'hA5;

  localparam logic [3:0] NIB_FWD [16] = '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
                                          4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7};
  localparam logic [3:0] NIB_INV [16] = '{4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
                                          4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5};
  localparam logic [3:0] GRP_MAP [16] = '{4'd4, 4'd12, 4'd8, 4'd0, 4'd9, 4'd1, 4'd13, 4'd5,
                                          4'd2, 4'd14, 4'd6, 4'd10, 4'd7, 4'd15, 4'd3, 4'd11};
  localparam logic [6:0] KEY_ROT [5] = '{7'd13, 7'd29, 7'd47, 7'd61, 7'd79};
  localparam logic [3:0] BYTE_STEP [5] = '{4'd1, 4'd3, 4'd5, 4'd7, 4'd2};
  localparam logic [127:0] RCON [5] = '{
    128'h9e3779b97f4a7c15f39cc0605cedc835,
    128'h3c6ef372fe94f82be73980c0b9db906a,
    128'hdaa66d2c7ddf7431dbd641a115c9649f,
    128'h78dde6e5fd29f047cf73018173b720d4,
    128'h1715609f7c746c5dc30fc1e1d1a5ad09};

  typedef logic [127:0] blk_t;
  typedef logic [2:0]   rnd_t;

  typedef enum logic [1:0] {ST_IDLE, ST_KEXP, ST_ENC, ST_DEC} state_t;

  typedef enum logic [1:0] {OP_KEY, OP_ENC, OP_DEC} op_t;

  // control from sequencer to round unit
  typedef struct packed {
    op_t  op;
    rnd_t rnd;
  } rctl_t;

  localparam logic [0:0] REQ_ENC = 1'b0;
  localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

  // byte i of the block (byte 0 = MSB)
  function automatic logic [7:0] get_byte(blk_t b, int i);
    get_byte = b[127 - 8*i -: 8];
  endfunction

  function automatic blk_t nib_sub(blk_t b, logic inv);
    blk_t o;
    for (int i = 0; i < 32; i++) begin
      o[4*i +: 4] = inv ? NIB_INV[b[4*i +: 4]] : NIB_FWD[b[4*i +: 4]];
    end
    nib_sub = o;
  endfunction

  // bit k moves to (k & ~15) + GRP_MAP[k & 15], bit 0 = MSB
  function automatic blk_t bit_perm(blk_t b, logic inv);
    blk_t o;
    int d;
    for (int k = 0; k < 128; k++) begin
      d = (k & ~15) + int'(GRP_MAP[k & 15]);
      if (inv) o[127 - k] = b[127 - d];
      else     o[127 - d] = b[127 - k];
    end
    bit_perm = o;
  endfunction

  function automatic logic [7:0] fwd_byte(logic [7:0] x);
    fwd_byte = {NIB_FWD[x[7:4]], NIB_FWD[x[3:0]]};
  endfunction

  function automatic logic [7:0] swp_byte(logic [7:0] x);
    swp_byte = {NIB_FWD[x[3:0]], NIB_FWD[x[7:4]]} ^ MixXor;
  endfunction

  function automatic blk_t pair_mix(blk_t b);
    blk_t o;
    logic [7:0] a, c;
    for (int i = 0; i < 16; i += 2) begin
      a = b[127 - 8*i -: 8];
      c = b[119 - 8*i -: 8];
      o[127 - 8*i -: 8] = a ^ fwd_byte(a) ^ swp_byte(c);
      o[119 - 8*i -: 8] = c ^ fwd_byte(c) ^ swp_byte(a);
    end
    pair_mix = o;
  endfunction

  // prefix XOR over bytes, then byte rotate left by n
  function automatic blk_t spread(blk_t b, logic [3:0] n);
    blk_t p, o;
    p[127 -: 8] = b[127 -: 8];
    for (int i = 1; i < 16; i++) begin
      p[127 - 8*i -: 8] = b[127 - 8*i -: 8] ^ p[135 - 8*i -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*i -: 8] = p[127 - 8*((i + int'(n)) & 15) -: 8];
    end
    spread = o;
  endfunction

  function automatic blk_t unspread(blk_t b, logic [3:0] n);
    blk_t o, q;
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*((i + int'(n)) & 15) -: 8] = b[127 - 8*i -: 8];
    end
    q[127 -: 8] = o[127 -: 8];
    for (int i = 1; i < 16; i++) begin
      q[127 - 8*i -: 8] = o[127 - 8*i -: 8] ^ o[135 - 8*i -: 8];
    end
    unspread = q;
  endfunction

endpackage
`default_nettype wire

/* hdl/spn_block_cipher_128.sv */
// Channel  | Ports                                  | Handshake
// input    | in_req_type, in_block_high/low         | start & !busy
// result   | out_result_high/low                    | out_valid, one cycle
// config   | cfg_we, cfg_index, cfg_wdata           | cfg_we
//
// From accept to out_valid, each round fetches its 128-bit key from the
// store's single 64-bit read port in two halves, then makes one pass of the
// shared round unit; busy drops with out_valid unless a key write is pending.
// A key write holds busy until all round keys are re-expanded, one 64-bit
// half of expansion per cycle. Reset is synchronous, active low, and clears
// control; the round-key store is not cleared. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "spn_block_cipher_128_defines.svh"
module spn_block_cipher_128 import spn_pkg::*; #(
  parameter int ROUND_COUNT = RoundCountDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [63:0] in_block_high,
  input  wire logic [63:0] in_block_low,
  output logic             out_valid,
  output logic [63:0]      out_result_high,
  output logic [63:0]      out_result_low,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  localparam int Depth = 2 * ROUND_COUNT;
  localparam int AW    = $clog2(Depth);

  state_t     state_r, state_nxt;
  rnd_t       rnd_r, rnd_nxt;
  logic       half_r, half_nxt;   // 0: fetch high half, 1: fetch low half (key expansion also applies)
  logic [63:0] key_high_r, key_low_r;
  logic [63:0] rk_hi_r;
  blk_t       dat_r;
  logic       out_valid_r;
  logic       kexp_req_r;
  rctl_t      ctl;
  blk_t       rnd_out;
  logic       we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata, rdata;
  logic       rd_pend_r;

  assign busy = (state_r != ST_IDLE) || kexp_req_r;

  // key registers; a write requests re-expansion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      kexp_req_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_KEY_HIGH) key_high_r <= cfg_wdata;
        else                           key_low_r  <= cfg_wdata;
        kexp_req_r <= 1'b1;
      end else if (state_r == ST_IDLE) begin
        kexp_req_r <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    half_nxt  = half_r;
    case (state_r)
      ST_IDLE: begin
        half_nxt = 1'b0;
        if (kexp_req_r && !cfg_we) begin
          state_nxt = ST_KEXP;
          rnd_nxt   = '0;
        end else if (start && !kexp_req_r) begin
          state_nxt = (in_req_type == REQ_ENC) ? ST_ENC : ST_DEC;
          rnd_nxt   = (in_req_type == REQ_ENC) ? rnd_t'(0) : rnd_t'(ROUND_COUNT - 1);
        end
      end
      ST_KEXP: begin
        half_nxt = !half_r;
        if (half_r) begin
          if (rnd_r == rnd_t'(ROUND_COUNT - 1)) state_nxt = ST_IDLE;
          else rnd_nxt = rnd_r + 3'd1;
        end
      end
      ST_ENC, ST_DEC: begin
        // half 0: issue high read; half 1: high ready, issue low; then apply
        if (!rd_pend_r) begin
          half_nxt = !half_r;
        end else begin
          half_nxt = 1'b0;
          if ((state_r == ST_ENC && rnd_r == rnd_t'(ROUND_COUNT - 1)) ||
              (state_r == ST_DEC && rnd_r == '0)) begin
            state_nxt = ST_IDLE;
          end else if (state_r == ST_ENC) begin
            rnd_nxt = rnd_r + 3'd1;
          end else begin
            rnd_nxt = rnd_r - 3'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of sequencer
  always_comb begin
    ctl.rnd = rnd_r;
    case (state_r)
      ST_KEXP: ctl.op = OP_KEY;
      ST_DEC:  ctl.op = OP_DEC;
      default: ctl.op = OP_ENC;
    endcase
    we    = (state_r == ST_KEXP);
    waddr = AW'({rnd_r, half_r});
    wdata = half_r ? rnd_out[63:0] : rnd_out[127:64];
    raddr = AW'({rnd_r, half_r});
  end

  spn_round u_round (
    .ctl  (ctl),
    .din  (dat_r),
    .rk   ({rk_hi_r, rdata}),
    .dout (rnd_out)
  );

  spn_ram #(.Width(64), .Depth(Depth)) u_rk_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      half_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      half_r      <= half_nxt;
      rd_pend_r   <= (state_r == ST_ENC || state_r == ST_DEC) && half_r && !rd_pend_r;
      out_valid_r <= (state_r == ST_ENC || state_r == ST_DEC) && rd_pend_r &&
                     (state_nxt == ST_IDLE);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      if (kexp_req_r && !cfg_we) dat_r <= {key_high_r, key_low_r};
      else if (start)            dat_r <= {in_block_high, in_block_low};
    end else if (state_r == ST_KEXP) begin
      if (half_r) dat_r <= rnd_out;
    end else if (rd_pend_r) begin
      dat_r <= rnd_out;
    end
    if ((state_r == ST_ENC || state_r == ST_DEC) && half_r && !rd_pend_r) begin
      rk_hi_r <= rdata;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_high = dat_r[127:64];
  assign out_result_low  = dat_r[63:0];

  `SPN_ASSERT_IMP(a_no_start_busy, out_valid, state_r == ST_IDLE, "result outside idle")
  `SPN_ASSERT_NEXT(a_kexp_busy, cfg_we, busy, "key write not seen as busy")
  `SPN_ASSERT_IMP(a_no_we_in_round, state_r == ST_ENC || state_r == ST_DEC, !we,
                  "round-key write during block")
endmodule
`default_nettype wire

/* hdl/spn_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module spn_ram #(
  parameter int Width = 64,
  parameter int Depth = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/spn_round.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared round unit: one key-expansion, encrypt or decrypt round
module spn_round import spn_pkg::*; (
  input  wire rctl_t      ctl,
  input  wire blk_t       din,
  input  wire blk_t       rk,
  output blk_t            dout
);
  blk_t rot;
  blk_t t;

  always_comb begin
    rot  = (din << KEY_ROT[ctl.rnd]) | (din >> (7'd0 - KEY_ROT[ctl.rnd]));
    dout = din;
    case (ctl.op)
      OP_KEY: begin
        t    = pair_mix(bit_perm(nib_sub(rot, 1'b0), 1'b0));
        dout = t ^ RCON[ctl.rnd];
      end
      OP_ENC: begin
        t    = bit_perm(nib_sub(din ^ rk, 1'b0), 1'b0);
        dout = spread(t, BYTE_STEP[ctl.rnd]);
      end
      OP_DEC: begin
        t    = nib_sub(bit_perm(unspread(din, BYTE_STEP[ctl.rnd]), 1'b1), 1'b1);
        dout = t ^ rk;
      end
      default: begin
        t    = din;
        dout = din;
      end
    endcase
  end
endmodule
`default_nettype wire
